/* rtl/bsdr_pkg.sv */
// ----------------------------------------------------------------------------
// bsdr_pkg
// Shared widths, register indexes, reset values and the pipeline control
// word for the Bezier step delay ramp.
// ----------------------------------------------------------------------------
package bsdr_pkg;

  localparam int ACCEL_W   = 16;
  localparam int DELAY_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = 2'd2;

  // Reset values
  localparam logic [ACCEL_W-1:0] RAMP_LEN_RST  = 16'd200;
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 16'd2000;
  localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 16'd500;

  // Control word that travels with each pipeline stage
  typedef struct packed {
    logic valid;  // stage holds a live word
    logic ramp;   // word lies in a ramp; otherwise the answer is cruise delay
  } ctl_t;

endpackage

/* rtl/bsdr_divider.sv */
// ----------------------------------------------------------------------------
// bsdr_divider
// Pipelined restoring divider: quotient = floor(num * 2^FRAC_BITS / den)
// for num < den, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module bsdr_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsdr_pkg::ctl_t               ctl_i,
  input  logic [bsdr_pkg::ACCEL_W-1:0] num_i,
  input  logic [bsdr_pkg::ACCEL_W-1:0] den_i,
  output bsdr_pkg::ctl_t               ctl_o,
  output logic [FRAC_BITS-1:0]         quot_o
);

  localparam int AW = bsdr_pkg::ACCEL_W;

  logic [AW-1:0]        rem_r  [FRAC_BITS-1];
  logic [FRAC_BITS-1:0] quot_r [FRAC_BITS];
  bsdr_pkg::ctl_t       ctl_r  [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic [AW-1:0]        rem_in;
    logic [FRAC_BITS-1:0] q_in;
    bsdr_pkg::ctl_t       c_in;
    logic [AW:0]          shifted;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign q_in   = '0;
      assign c_in   = ctl_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = quot_r[k-1];
      assign c_in   = ctl_r[k-1];
    end

    // shift in one zero bit of the dividend, subtract when it fits
    assign shifted = {rem_in, 1'b0};
    assign take    = (shifted >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= c_in;
      end
    end

    always_ff @(posedge clk) begin
      quot_r[k] <= {q_in[FRAC_BITS-2:0], take};
    end

    if (k < FRAC_BITS - 1) begin : g_rem
      logic [AW-1:0] diff;

      // the difference is below den when taken, so the low bits suffice
      assign diff = shifted[AW-1:0] - den_i;

      always_ff @(posedge clk) begin
        rem_r[k] <= take ? diff : shifted[AW-1:0];
      end
    end
  end

  assign ctl_o  = ctl_r[FRAC_BITS-1];
  assign quot_o = quot_r[FRAC_BITS-1];

endmodule

/* rtl/bsdr_curve.sv */
// ----------------------------------------------------------------------------
// bsdr_curve
// Cubic Bezier easing of t in Q0.F and scaling into the delay range,
// seven register stages, at most one multiply level per stage.
// ----------------------------------------------------------------------------
module bsdr_curve #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsdr_pkg::ctl_t               ctl_i,
  input  logic [FRAC_BITS-1:0]         t_i,
  input  logic [bsdr_pkg::DELAY_W-1:0] max_delay_i,
  input  logic [bsdr_pkg::DELAY_W-1:0] min_delay_i,
  output logic                         valid_o,
  output logic [bsdr_pkg::DELAY_W-1:0] delay_o
);

  localparam int F  = FRAC_BITS;
  localparam int DW = bsdr_pkg::DELAY_W;
  localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
  localparam longint unsigned P1_L  = (65 * ONE_L + 50) / 100;
  localparam longint unsigned P2_L  = (85 * ONE_L + 50) / 100;
  localparam logic [F-1:0] P1    = P1_L[F-1:0];
  localparam logic [F-1:0] P2    = P2_L[F-1:0];
  localparam logic [F:0]   ONE_Q = {1'b1, {F{1'b0}}};

  bsdr_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r;

  // stage 1: u = 1 - t, squares
  logic [F:0]     u_nxt;
  logic [2*F+1:0] uu;
  logic [2*F-1:0] tt;
  logic [F-1:0]   t1_r;
  logic [F:0]     u1_r;
  logic [F:0]     a1_r;
  logic [F-1:0]   b1_r;

  assign u_nxt = ONE_Q - {1'b0, t_i};
  assign uu    = (2*F+2)'(u_nxt) * (2*F+2)'(u_nxt);
  assign tt    = (2*F)'(t_i) * (2*F)'(t_i);

  always_ff @(posedge clk) begin
    t1_r <= t_i;
    u1_r <= u_nxt;
    a1_r <= uu[2*F:F];
    b1_r <= tt[2*F-1:F];
  end

  // stage 2: cubic terms
  logic [2*F:0]   at;
  logic [2*F:0]   ub;
  logic [2*F-1:0] bt;
  logic [F-1:0]   c1_r, c2_r, c3_2_r;

  assign at = (2*F+1)'(a1_r) * (2*F+1)'(t1_r);
  assign ub = (2*F+1)'(u1_r) * (2*F+1)'(b1_r);
  assign bt = (2*F)'(b1_r) * (2*F)'(t1_r);

  always_ff @(posedge clk) begin
    c1_r   <= at[2*F-1:F];
    c2_r   <= ub[2*F-1:F];
    c3_2_r <= bt[2*F-1:F];
  end

  // stage 3: weight by control points
  logic [2*F-1:0] m1_r, m2_r;
  logic [F-1:0]   c3_3_r;

  always_ff @(posedge clk) begin
    m1_r   <= (2*F)'(c1_r) * (2*F)'(P1);
    m2_r   <= (2*F)'(c2_r) * (2*F)'(P2);
    c3_3_r <= c3_2_r;
  end

  // stage 4: sum of weighted terms
  logic [2*F:0] s4_r;
  logic [F-1:0] c3_4_r;

  always_ff @(posedge clk) begin
    s4_r   <= (2*F+1)'(m1_r) + (2*F+1)'(m2_r);
    c3_4_r <= c3_3_r;
  end

  // stage 5: times three, drop fraction, add t^3, clamp to one
  logic [2*F+2:0] tri3;
  logic [F+3:0]   bz_raw;
  logic [F:0]     bz5_r;

  assign tri3   = (2*F+3)'({s4_r, 1'b0}) + (2*F+3)'(s4_r);
  assign bz_raw = (F+4)'(tri3[2*F+2:F]) + (F+4)'(c3_4_r);

  always_ff @(posedge clk) begin
    bz5_r <= (bz_raw > (F+4)'(ONE_Q)) ? ONE_Q : bz_raw[F:0];
  end

  // stage 6: scale by the delay span
  logic          up_ramp;
  logic [DW-1:0] span;
  logic [F+DW:0] prod6_r;

  assign up_ramp = (max_delay_i >= min_delay_i);
  assign span    = up_ramp ? (max_delay_i - min_delay_i) : (min_delay_i - max_delay_i);

  always_ff @(posedge clk) begin
    prod6_r <= (F+DW+1)'(bz5_r) * (F+DW+1)'(span);
  end

  // stage 7: floor or ceiling of the scaled span, apply to max delay
  logic [F+DW+1:0] prod_up;
  logic [DW+1:0]   res;
  logic            valid7_r;
  logic [DW-1:0]   delay7_r;

  assign prod_up = (F+DW+2)'(prod6_r) + (F+DW+2)'(ONE_Q - (F+1)'(1));
  assign res     = up_ramp ? ((DW+2)'(max_delay_i) - (DW+2)'(prod6_r[F+DW:F]))
                           : ((DW+2)'(max_delay_i) + prod_up[F+DW+1:F]);

  always_ff @(posedge clk) begin
    delay7_r <= ctl6_r.ramp ? res[DW-1:0] : min_delay_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r   <= '0;
      ctl2_r   <= '0;
      ctl3_r   <= '0;
      ctl4_r   <= '0;
      ctl5_r   <= '0;
      ctl6_r   <= '0;
      valid7_r <= 1'b0;
    end else begin
      ctl1_r   <= ctl_i;
      ctl2_r   <= ctl1_r;
      ctl3_r   <= ctl2_r;
      ctl4_r   <= ctl3_r;
      ctl5_r   <= ctl4_r;
      ctl6_r   <= ctl5_r;
      valid7_r <= ctl6_r.valid;
    end
  end

  assign valid_o = valid7_r;
  assign delay_o = delay7_r;

endmodule

/* rtl/bezier_step_delay_ramp.sv */
// ----------------------------------------------------------------------------
// bezier_step_delay_ramp
// Stepper inter-step delay with cubic Bezier acceleration and deceleration.
// ----------------------------------------------------------------------------
// One query (step index, move length) enters on any cycle with start high;
// busy never rises, so a query can be issued every clock. Each query gives
// exactly one delay word on out_delay_us, marked by a one-cycle out_valid
// strobe. The receiver cannot stall: it must capture every strobe. Each
// query passes the stage-0 register, then the ramp-position divider, which
// produces one quotient bit per stage, then seven stages of curve arithmetic.
// Queries are independent and answers come out in order. Configuration
// registers (0: ramp length, 1: max_delay_us, 2: min_delay_us) take a write
// whenever cfg_valid is high; write them only with no query in flight.
// A ramp length of zero disables both ramps and every step answers the
// cruise delay. If min_delay_us exceeds max_delay_us the ramp runs upward.
// ----------------------------------------------------------------------------
module bezier_step_delay_ramp #(
  parameter int STEP_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // query channel
  input  logic                           start,
  output logic                           busy,
  input  logic [STEP_BITS-1:0]           in_step_index,
  input  logic [STEP_BITS-1:0]           in_move_length,
  // result channel
  output logic                           out_valid,
  output logic [bsdr_pkg::DELAY_W-1:0]   out_delay_us,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsdr_pkg::DELAY_W-1:0]   cfg_data
);

  localparam int AW      = bsdr_pkg::ACCEL_W;
  localparam int CMP_W   = ((STEP_BITS > AW) ? STEP_BITS : AW) + 1;
  localparam int LATENCY = FRAC_BITS + 8;

  // --------------------------------------------------------------------------
  // Configuration registers; the port never pushes back
  // --------------------------------------------------------------------------
  logic [AW-1:0]                  ramp_len_r;
  logic [bsdr_pkg::DELAY_W-1:0]   max_delay_r;
  logic [bsdr_pkg::DELAY_W-1:0]   min_delay_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_len_r  <= bsdr_pkg::RAMP_LEN_RST;
      max_delay_r <= bsdr_pkg::MAX_DELAY_RST;
      min_delay_r <= bsdr_pkg::MIN_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bsdr_pkg::REG_RAMP_LEN:  ramp_len_r  <= cfg_data;
        bsdr_pkg::REG_MAX_DELAY: max_delay_r <= cfg_data;
        bsdr_pkg::REG_MIN_DELAY: min_delay_r <= cfg_data;
        default: ;  // unmapped index: drop the word
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: classify the step (ramp up, ramp down, cruise) and pick the
  // ramp position numerator. Both ramp numerators stay below the ramp
  // length, so they fit the register width.
  // --------------------------------------------------------------------------
  logic             in_accept;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] acc_ext;
  logic [CMP_W-1:0] idx_plus_acc;
  logic [CMP_W-1:0] remain;
  logic             in_up;
  logic             in_down;
  bsdr_pkg::ctl_t   ctl_nxt;
  bsdr_pkg::ctl_t   s0_ctl_r;
  logic [AW-1:0]    s0_num_r;

  assign in_accept    = start && !busy;
  assign idx_ext      = CMP_W'(in_step_index);
  assign len_ext      = CMP_W'(in_move_length);
  assign acc_ext      = CMP_W'(ramp_len_r);
  assign idx_plus_acc = idx_ext + acc_ext;
  // steps remaining, taken as zero past the end of the move
  assign remain       = (idx_ext > len_ext) ? '0 : (len_ext - idx_ext);
  assign in_up        = (idx_ext < acc_ext);
  assign in_down      = (idx_plus_acc > len_ext);

  always_comb begin
    ctl_nxt.valid = in_accept;
    ctl_nxt.ramp  = (ramp_len_r != '0) && (in_up || in_down);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
    end else begin
      s0_ctl_r <= ctl_nxt;
    end
  end

  // ramp-up rule wins where the two ramps overlap
  always_ff @(posedge clk) begin
    s0_num_r <= in_up ? idx_ext[AW-1:0] : remain[AW-1:0];
  end

  // --------------------------------------------------------------------------
  // Ramp position t = num / ramp length in Q0.FRAC_BITS
  // --------------------------------------------------------------------------
  bsdr_pkg::ctl_t       div_ctl;
  logic [FRAC_BITS-1:0] div_t;

  bsdr_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (s0_ctl_r),
    .num_i  (s0_num_r),
    .den_i  (ramp_len_r),
    .ctl_o  (div_ctl),
    .quot_o (div_t)
  );

  // --------------------------------------------------------------------------
  // Bezier easing and delay scaling; cruise steps answer min_delay_us
  // --------------------------------------------------------------------------
  bsdr_curve #(
    .FRAC_BITS (FRAC_BITS)
  ) u_curve (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (div_ctl),
    .t_i         (div_t),
    .max_delay_i (max_delay_r),
    .min_delay_i (min_delay_r),
    .valid_o     (out_valid),
    .delay_o     (out_delay_us)
  );

`ifndef ASSERT_OFF
  // every result strobe traces back to a query taken a fixed latency earlier
  a_result_has_query: assert property (@(posedge clk)
    out_valid |-> $past(in_accept && rst_n, LATENCY))
    else $error("result strobe without a matching query");

  // reset empties the pipeline: no stray strobe right after reset
  a_reset_flushes: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result strobe right after reset");
`endif

endmodule

/* tb/tb_bezier_step_delay_ramp.sv */
// ----------------------------------------------------------------------------
// tb_bezier_step_delay_ramp
// Self-checking bench for the Bezier step delay ramp. A directed table
// probes the ramp ends, the cruise section, the deceleration boundary and
// steps past the end of the move. Random queries then run under several
// register settings: no ramps, inverted limits, flat limits and the widest values.
// Each delay word is compared in order with a fixed-point predictor or pinned delay.
// ----------------------------------------------------------------------------
module tb_bezier_step_delay_ramp;

  localparam int STEP_W         = 24;
  localparam int FRAC_W         = 16;
  localparam int PHASE_ITEMS    = 235;
  localparam int WATCHDOG_LIMIT = 2000;
  // pipeline depth plus some margin, used for the quiet tail at the end
  localparam int TAIL_CYCLES    = FRAC_W + 8 + 16;

  localparam int DELAY_W   = bsdr_pkg::DELAY_W;
  localparam int ACCEL_W   = bsdr_pkg::ACCEL_W;
  localparam int CFG_IDX_W = bsdr_pkg::CFG_IDX_W;

  // index 3 decodes to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Q1.16 unity and the two inner control points in Q0.16, rounded to nearest
  localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_W;
  localparam logic [63:0] CURVE_P1 = (64'd65 * ONE_Q + 64'd50) / 64'd100;
  localparam logic [63:0] CURVE_P2 = (64'd85 * ONE_Q + 64'd50) / 64'd100;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [STEP_W-1:0]    in_step_index;
  logic [STEP_W-1:0]    in_move_length;
  logic                 out_valid;
  logic [DELAY_W-1:0]   out_delay_us;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELAY_W-1:0]   cfg_data;

  // Directed rows may carry a delay typed in by hand; it travels beside the
  // query word and replaces the predictor for that one row.
  logic                 pin_flag;
  logic [DELAY_W-1:0]   pin_delay;

  // Shadow copy of the three registers, tracked from accepted writes
  logic [ACCEL_W-1:0]   ramp_steps;
  logic [DELAY_W-1:0]   slow_delay;
  logic [DELAY_W-1:0]   fast_delay;

  logic [DELAY_W-1:0]   delay_q[$];   // delays still owed by the block, oldest first
  int                   mismatch_cnt;
  int                   idle_cycles;
  bit                   no_idle;

  typedef struct packed {
    logic [STEP_W-1:0]  idx;
    logic [STEP_W-1:0]  len;
    logic               pinned;
    logic [DELAY_W-1:0] delay;
  } probe_t;

  typedef struct packed {
    logic [ACCEL_W-1:0] accel;
    logic [DELAY_W-1:0] slow;
    logic [DELAY_W-1:0] fast;
  } reg_set_t;

  // Directed queries, run under the reset register values (200, 2000, 500)
  localparam int NUM_PROBES = 18;
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{24'd0,       24'd1000,    1'b1, 16'd2000},  // first step: slowest delay
    '{24'd500,     24'd1000,    1'b1, 16'd500},   // middle of move: cruise
    '{24'd1000,    24'd1000,    1'b1, 16'd2000},  // no steps left
    '{24'd5000,    24'd1000,    1'b1, 16'd2000},  // step beyond the move
    '{24'hFFFFFF,  24'hFFFFFF,  1'b1, 16'd2000},  // all ones, nothing left
    '{24'd0,       24'd0,       1'b1, 16'd2000},  // empty move
    '{24'd199,     24'd0,       1'b0, 16'd0},     // last ramp-up step
    '{24'd100,     24'd150,     1'b0, 16'd0},     // ramps overlap, ramp-up wins
    '{24'd200,     24'd400,     1'b1, 16'd500},   // decel test exactly at equality
    '{24'd201,     24'd400,     1'b0, 16'd0},     // first decel step
    '{24'hFFFFFF,  24'd0,       1'b1, 16'd2000},  // far beyond a zero-length move
    '{24'd0,       24'hFFFFFF,  1'b1, 16'd2000},  // longest move, first step
    '{24'h800000,  24'hFFFFFF,  1'b1, 16'd500},   // longest move, cruise
    '{24'd100,     24'd100000,  1'b0, 16'd0},     // halfway up the ramp
    '{24'hAAAAAA,  24'h555555,  1'b1, 16'd2000},  // alternating bits, beyond
    '{24'h555555,  24'hAAAAAA,  1'b1, 16'd500},   // alternating bits, cruise
    '{24'd1,       24'd100000,  1'b0, 16'd0},     // second step
    '{24'hFFFF39,  24'hFFFFFF,  1'b0, 16'd0}      // decel near the top of range
  };

  // Register settings for the later phases: no ramps, widest falling ramp,
  // widest inverted ramp, flat limits, and an inverted short ramp.
  localparam int NUM_SETS = 5;
  localparam reg_set_t REG_SETS [NUM_SETS] = '{
    '{16'd0,     16'd3000,  16'd700},
    '{16'd1,     16'hFFFF,  16'd0},
    '{16'hFFFF,  16'd0,     16'hFFFF},
    '{16'd3,     16'd1000,  16'd1000},
    '{16'd50,    16'd100,   16'd60000}
  };

  bezier_step_delay_ramp #(
    .STEP_BITS(STEP_W),
    .FRAC_BITS(FRAC_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_step_index (in_step_index),
    .in_move_length(in_move_length),
    .out_valid     (out_valid),
    .out_delay_us  (out_delay_us),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Delay predictor
  // --------------------------------------------------------------------------

  // Cubic easing curve in Q1.16; products are truncated to 16 fraction bits
  function automatic logic [63:0] bezier_frac(input logic [63:0] t);
    logic [63:0] u, uu, tt, c1, c2, c3, bz;
    u  = ONE_Q - t;
    uu = (u * u) >> FRAC_W;
    tt = (t * t) >> FRAC_W;
    c1 = (uu * t) >> FRAC_W;
    c2 = (u * tt) >> FRAC_W;
    c3 = (tt * t) >> FRAC_W;
    bz = ((64'd3 * c1 * CURVE_P1 + 64'd3 * c2 * CURVE_P2) >> FRAC_W) + c3;
    return (bz > ONE_Q) ? ONE_Q : bz;
  endfunction

  // Scale the curve onto the delay span; floor toward minus infinity, so an
  // inverted span rounds its (negative) step up in magnitude.
  function automatic logic [DELAY_W-1:0] delay_from_pos(input logic [63:0] t);
    logic [63:0] bz;
    longint      drop;
    longint      res;
    bz = bezier_frac(t);
    if (slow_delay >= fast_delay) begin
      drop = longint'((bz * (64'(slow_delay) - 64'(fast_delay))) >> FRAC_W);
    end else begin
      drop = -longint'((bz * (64'(fast_delay) - 64'(slow_delay)) + ONE_Q - 64'd1)
                       >> FRAC_W);
    end
    res = longint'(64'(slow_delay)) - drop;
    if (res < 0) res = 0;
    if (res > 65535) res = 65535;
    return res[DELAY_W-1:0];
  endfunction

  function automatic logic [DELAY_W-1:0] predict_delay(input logic [STEP_W-1:0] idx,
                                                       input logic [STEP_W-1:0] len);
    logic [63:0] i, l, a, left;
    i = 64'(idx);
    l = 64'(len);
    a = 64'(ramp_steps);
    if (a == 0) return fast_delay;
    if (i < a) return delay_from_pos((i << FRAC_W) / a);
    if (i + a > l) begin
      // past the end of the move counts as no steps left
      left = (i > l) ? 64'd0 : l - i;
      return delay_from_pos((left << FRAC_W) / a);
    end
    return fast_delay;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [DELAY_W-1:0] got,
                                 input logic [DELAY_W-1:0] want);
    mismatch_cnt++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // Sample every handshake at the rising edge. Push the new query's delay
  // before popping, so even an answer in its query's own cycle lines up with it.
  always @(posedge clk) begin : monitor
    logic [DELAY_W-1:0] want;
    logic               moved;
    if (!rst_n) begin
      ramp_steps  = bsdr_pkg::RAMP_LEN_RST;
      slow_delay  = bsdr_pkg::MAX_DELAY_RST;
      fast_delay  = bsdr_pkg::MIN_DELAY_RST;
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (start && !busy) begin
        want = pin_flag ? pin_delay : predict_delay(in_step_index, in_move_length);
        delay_q.push_back(want);
        moved = 1'b1;
      end
      if (out_valid) begin
        moved = 1'b1;
        if (delay_q.size() == 0) begin
          report_mismatch("unexpected delay word", out_delay_us, 16'd0);
        end else begin
          want = delay_q.pop_front();
          if (out_delay_us !== want) report_mismatch("delay_us", out_delay_us, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          bsdr_pkg::REG_RAMP_LEN:  ramp_steps = cfg_data;
          bsdr_pkg::REG_MAX_DELAY: slow_delay = cfg_data;
          bsdr_pkg::REG_MIN_DELAY: fast_delay = cfg_data;
          default: ;
        endcase
      end
      // watchdog: a long stretch with no word moving anywhere is a hang
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one; during a
  // burst stretch the sender does not idle at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drive one query word at the falling edge and hold it until taken
  task automatic send_query(input logic [STEP_W-1:0] idx, input logic [STEP_W-1:0] len,
                            input logic pinned, input logic [DELAY_W-1:0] lit);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_step_index  <= idx;
    in_move_length <= len;
    pin_flag       <= pinned;
    pin_delay      <= lit;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every owed delay word has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (delay_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input reg_set_t s);
    write_reg(bsdr_pkg::REG_RAMP_LEN,  s.accel);
    write_reg(bsdr_pkg::REG_MAX_DELAY, s.slow);
    write_reg(bsdr_pkg::REG_MIN_DELAY, s.fast);
  endtask

  // Aim most queries at the ramps and the boundaries around them: ramp-up
  // steps, the last ramp-length steps of a move, and steps just past its end.
  // Moves are often short enough that the two ramps overlap.
  task automatic pick_query(output logic [STEP_W-1:0] idx, output logic [STEP_W-1:0] len);
    int unsigned a, i, l, back;
    int          mode;
    a    = (ramp_steps == 0) ? 200 : ramp_steps;
    mode = $urandom_range(0, 9);
    l    = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3 * a) : ($urandom & 32'hFFFFFF);
    case (mode)
      0, 1, 2: i = $urandom_range(0, a);
      3, 4, 5: begin
        back = $urandom_range(0, a + 1);
        if ($urandom_range(0, 7) == 0) i = l + $urandom_range(1, 4);
        else if (back > l)             i = $urandom_range(0, l);
        else                           i = l - back;
      end
      6: begin
        if (l < 2 * a) l = 2 * a + $urandom_range(0, 1000);
        i = $urandom_range(a, l - a);
      end
      default: begin
        i = $urandom & 32'hFFFFFF;
        l = $urandom & 32'hFFFFFF;
      end
    endcase
    idx = i[STEP_W-1:0];
    len = l[STEP_W-1:0];
  endtask

  task automatic run_random(input int n);
    logic [STEP_W-1:0] idx, len;
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // now and then hold the sender until the pipeline is empty
      if ($urandom_range(0, 99) == 0) drain();
      pick_query(idx, len);
      send_query(idx, len, 1'b0, '0);
    end
    drain();
  endtask

  initial begin
    reg_set_t rs;
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_step_index  = '0;
    in_move_length = '0;
    pin_flag       = 1'b0;
    pin_delay      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = bsdr_pkg::REG_RAMP_LEN;
    cfg_data       = '0;
    mismatch_cnt   = 0;
    no_idle        = 1'b0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset values first: walk the directed table, then random queries
    foreach (PROBES[r]) send_query(PROBES[r].idx, PROBES[r].len, PROBES[r].pinned,
                                   PROBES[r].delay);
    run_random(PHASE_ITEMS);

    foreach (REG_SETS[p]) begin
      load_regs(REG_SETS[p]);
      // a write to the unused index must leave the flat-limit setting alone
      if (p == 3) write_reg(REG_SPARE, DELAY_W'($urandom));
      run_random(PHASE_ITEMS);
    end

    // two random settings, mostly short ramps
    repeat (2) begin
      rs.accel = ACCEL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                       : $urandom_range(1, 600));
      rs.slow  = DELAY_W'($urandom);
      rs.fast  = DELAY_W'($urandom);
      load_regs(rs);
      run_random(PHASE_ITEMS);
    end

    // let any stray word surface before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (delay_q.size() != 0) report_mismatch("missing delay word", '0, delay_q[0]);

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bsdr_pkg.sv
rtl/bsdr_divider.sv
rtl/bsdr_curve.sv
rtl/bezier_step_delay_ramp.sv
tb/tb_bezier_step_delay_ramp.sv
